// ===== src/flseq_pkg.sv =====
package flseq_pkg;

  // Memory geometry
  localparam int MemMegabytes = 32;
  localparam int PageBytes    = 256;
  localparam int SectorBytes  = 4096;

  localparam int PtrW    = 26;   // write pointer and erased limit
  localparam int AddrW   = 25;   // address sent to the flash
  localparam int LenW    = 8;    // request length, written count, data offset
  localparam int PieceW  = 9;    // page program data length
  localparam int MarginW = 10;
  localparam int PageW   = $clog2(PageBytes);
  localparam int MemBytes = MemMegabytes * (1 << 20);

  // Field widths on the stream ports
  localparam int KindW    = 3;
  localparam int CmdW     = 8;
  localparam int InDataW  = 24;  // 18 bits of fields, padded to bytes
  localparam int OutDataW = 56;  // 51 bits of fields, padded to bytes

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;
  localparam logic [CfgIdxW-1:0] CfgStopMargin   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEraseOnDemand = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxChunk     = 2'd2;

  // SPI command bytes
  localparam logic [CmdW-1:0] CmdWren  = 8'h06;
  localparam logic [CmdW-1:0] CmdErase = 8'h21;
  localparam logic [CmdW-1:0] CmdProg  = 8'h12;
  localparam logic [CmdW-1:0] CmdRdsr  = 8'h05;
  localparam logic [CmdW-1:0] CmdNone  = 8'h00;

  typedef enum logic [1:0] {
    OpRestart = 2'd0,
    OpAppend  = 2'd1,
    OpStatus  = 2'd2
  } op_e;

  typedef enum logic [KindW-1:0] {
    KindWren  = 3'd0,
    KindErase = 3'd1,
    KindProg  = 3'd2,
    KindRdsr  = 3'd3,
    KindDone  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PhIdle      = 3'b001,
    PhEraseWait = 3'b010,
    PhProgWait  = 3'b100
  } phase_e;

  function automatic logic [CmdW-1:0] flash_cmd(kind_e k);
    logic [CmdW-1:0] c;
    case (k)
      KindWren:  c = CmdWren;
      KindErase: c = CmdErase;
      KindProg:  c = CmdProg;
      KindRdsr:  c = CmdRdsr;
      default:   c = CmdNone;
    endcase
    return c;
  endfunction

endpackage

// ===== src/flash_log_append_sequencer_core.sv =====
// Channel   | Dir | Handshake               | Payload
// ----------+-----+-------------------------+------------------------------------------
// s_axis    | in  | tvalid / tready         | tdata: opcode, chunk_length, status_byte
// m_axis    | out | tvalid / tready / tlast | tdata: flash cmd, address, offset, length,
//           |     |                         |        near_full; tuser: kind
// cfg       | in  | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// One input beat is taken per cycle while the group register is empty or
// sending its last beat. All pointer arithmetic for a beat is done in the
// accept cycle and the zero, one or three result beats land in a group
// register, which then drains one beat per cycle while m_axis_tready is high.
// The next input is taken in the cycle the last beat of a group leaves.
// rst_ni clears the pointers, the phase, the group count and the configuration registers to
// their defaults; no clearing pass is needed. Downstream stalls hold the group.
module flash_log_append_sequencer_core
  import flseq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  // Input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [1:0] opcode, [9:2] chunk_length,
                                              // [17:10] status_byte, rest zero

  // Flash commands and completions
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] flash_opcode, [32:8] flash_address,
                                              // [40:33] data_offset, [49:41] data_length,
                                              // [50] near_full, rest zero
  output logic [KindW-1:0]    m_axis_tuser,   // kind
  output logic                m_axis_tlast,

  // Register writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [MarginW-1:0] margin_q;
  logic               eod_q;
  logic [PieceW-1:0]  max_chunk_q;

  // Sequencer state
  phase_e            phase_q, phase_d;
  logic [PtrW-1:0]   wa_q, wa_d;       // write pointer
  logic [PtrW-1:0]   el_q, el_d;       // erased limit
  logic [LenW-1:0]   req_q, req_d;
  logic [LenW-1:0]   wc_q, wc_d;
  logic [PieceW-1:0] pl_q, pl_d;

  // Result group: either one beat, or write enable / command / read status
  logic [1:0]        grp_cnt_q, grp_cnt_d;   // beats still to send
  logic              grp_triple_q, grp_triple_d;
  kind_e             grp_kind_q, grp_kind_d; // single kind, or middle kind of a triple
  logic [AddrW-1:0]  grp_addr_q, grp_addr_d;
  logic [LenW-1:0]   grp_off_q, grp_off_d;
  logic [PieceW-1:0] grp_len_q, grp_len_d;
  logic              grp_nf_q, grp_nf_d;

  logic            in_acc, out_acc;
  op_e             in_op;
  logic [LenW-1:0] in_len, in_st;

  // Working values inside the comb block
  logic              start_work, start_piece;
  logic [PtrW-1:0]   diff;
  logic [PieceW-1:0] page_left, remaining, cap, piece;
  logic [PtrW-1:0]   room;
  kind_e             cur_kind;

  assign in_op  = op_e'(s_axis_tdata[1:0]);
  assign in_len = s_axis_tdata[9:2];
  assign in_st  = s_axis_tdata[17:10];

  assign s_axis_tready = (grp_cnt_q == 2'd0) || (grp_cnt_q == 2'd1 && m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (grp_cnt_q != 2'd0);
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  always_comb begin
    phase_d      = phase_q;
    wa_d         = wa_q;
    el_d         = el_q;
    req_d        = req_q;
    wc_d         = wc_q;
    pl_d         = pl_q;
    grp_cnt_d    = grp_cnt_q;
    grp_triple_d = grp_triple_q;
    grp_kind_d   = grp_kind_q;
    grp_addr_d   = grp_addr_q;
    grp_off_d    = grp_off_q;
    grp_len_d    = grp_len_q;
    grp_nf_d     = grp_nf_q;
    start_work   = 1'b0;
    start_piece  = 1'b0;
    diff         = '0;
    page_left    = '0;
    remaining    = '0;
    cap          = '0;
    piece        = '0;
    room         = '0;

    if (out_acc) begin
      grp_cnt_d = grp_cnt_q - 2'd1;
    end

    if (in_acc) begin
      grp_cnt_d    = 2'd0;
      grp_triple_d = 1'b0;
      grp_addr_d   = '0;
      grp_off_d    = '0;
      grp_len_d    = '0;

      case (in_op)
        OpRestart: begin
          wa_d    = '0;
          el_d    = '0;
          req_d   = '0;
          wc_d    = '0;
          pl_d    = '0;
          phase_d = PhIdle;
        end
        OpAppend: begin
          if (phase_q == PhIdle) begin
            req_d = in_len;
            wc_d  = '0;
            if (in_len == '0) begin
              grp_cnt_d  = 2'd1;
              grp_kind_d = KindDone;
            end else begin
              start_work = 1'b1;
            end
          end
        end
        OpStatus: begin
          if (phase_q == PhEraseWait) begin
            if (in_st != '0) begin
              grp_cnt_d  = 2'd1;
              grp_kind_d = KindRdsr;
            end else begin
              el_d       = el_q + PtrW'(SectorBytes);
              start_work = 1'b1;
            end
          end else if (phase_q == PhProgWait) begin
            if (in_st != '0) begin
              grp_cnt_d  = 2'd1;
              grp_kind_d = KindRdsr;
            end else begin
              wc_d = wc_q + pl_q[LenW-1:0];
              wa_d = wa_q + PtrW'(pl_q);
              if (wc_d >= req_q) begin
                phase_d    = PhIdle;
                grp_cnt_d  = 2'd1;
                grp_kind_d = KindDone;
              end else begin
                start_piece = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase

      // Erase ahead, with erase on demand set, when the erased window is not larger than the request
      if (start_work) begin
        diff = el_d - wa_d;
        if (eod_q && (diff <= PtrW'(req_d))) begin
          phase_d      = PhEraseWait;
          grp_cnt_d    = 2'd3;
          grp_triple_d = 1'b1;
          grp_kind_d   = KindErase;
          grp_addr_d   = el_d[AddrW-1:0];
        end else begin
          start_piece = 1'b1;
        end
      end

      // Piece: min of page space, bytes left and chunk cap
      if (start_piece) begin
        page_left = PieceW'(PageBytes) - PieceW'(wa_d[PageW-1:0]);
        remaining = PieceW'(req_d - wc_d);
        cap       = (max_chunk_q == '0) ? PieceW'(1) : max_chunk_q;
        piece     = page_left;
        if (remaining < piece) begin
          piece = remaining;
        end
        if (cap < piece) begin
          piece = cap;
        end
        pl_d         = piece;
        phase_d      = PhProgWait;
        grp_cnt_d    = 2'd3;
        grp_triple_d = 1'b1;
        grp_kind_d   = KindProg;
        grp_addr_d   = wa_d[AddrW-1:0];
        grp_off_d    = wc_d;
        grp_len_d    = piece;
      end

      // Near full, from the pointer as left by this beat
      room     = (wa_d >= PtrW'(MemBytes)) ? '0 : PtrW'(MemBytes) - wa_d;
      grp_nf_d = (room < (PtrW'(margin_q) << 10));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q     <= MarginW'(10);
      eod_q        <= 1'b1;
      max_chunk_q  <= PieceW'(250);
      phase_q      <= PhIdle;
      wa_q         <= '0;
      el_q         <= '0;
      req_q        <= '0;
      wc_q         <= '0;
      pl_q         <= '0;
      grp_cnt_q    <= '0;
      grp_triple_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgStopMargin:    margin_q    <= cfg_data_i[MarginW-1:0];
          CfgEraseOnDemand: eod_q       <= cfg_data_i[0];
          CfgMaxChunk:      max_chunk_q <= cfg_data_i[PieceW-1:0];
          default: ;
        endcase
      end
      phase_q      <= phase_d;
      wa_q         <= wa_d;
      el_q         <= el_d;
      req_q        <= req_d;
      wc_q         <= wc_d;
      pl_q         <= pl_d;
      grp_cnt_q    <= grp_cnt_d;
      grp_triple_q <= grp_triple_d;
    end
  end

  // Group payload, loaded only on accepted input
  always_ff @(posedge clk_i) begin
    grp_kind_q <= grp_kind_d;
    grp_addr_q <= grp_addr_d;
    grp_off_q  <= grp_off_d;
    grp_len_q  <= grp_len_d;
    grp_nf_q   <= grp_nf_d;
  end

  // Beat selection within a triple: write enable, command, read status
  always_comb begin
    if (!grp_triple_q) begin
      cur_kind = grp_kind_q;
    end else if (grp_cnt_q == 2'd3) begin
      cur_kind = KindWren;
    end else if (grp_cnt_q == 2'd2) begin
      cur_kind = grp_kind_q;
    end else begin
      cur_kind = KindRdsr;
    end
  end

  assign m_axis_tuser = cur_kind;
  assign m_axis_tlast = (grp_cnt_q == 2'd1);
  assign m_axis_tdata = {
    5'b0,
    grp_nf_q,
    (cur_kind == KindProg) ? grp_len_q : '0,
    (cur_kind == KindProg) ? grp_off_q : '0,
    (cur_kind == KindProg || cur_kind == KindErase) ? grp_addr_q : '0,
    flash_cmd(cur_kind)
  };

endmodule

// ===== dv/flash_log_append_sequencer_core_tb.sv =====
module flash_log_append_sequencer_core_tb
  import flseq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode value that the block must ignore
  localparam logic [1:0] OpSpare = 2'd3;

  // Directed rows with this count are checked against the predictor
  localparam int ByPredictor = -1;

  localparam int IdleLimit    = 5000;  // cycles with no beat on either side
  localparam int HoldCycles   = 80;    // long downstream stall
  localparam int PhaseItems   = 20;    // random beats that do something, per setting
  localparam int NumPhases    = 6;
  localparam int SettleCycles = 6;     // room for ignored beats still in flight
  localparam int DrainCycles  = 20;

  // Register settings walked by the random part; extremes included
  localparam logic [MarginW-1:0] MarginPlan [NumPhases] = '{1023, 0, 512, 10, 700, 1023};
  localparam logic               ErasePlan  [NumPhases] = '{1, 0, 1, 1, 0, 1};
  localparam logic [PieceW-1:0]  ChunkPlan  [NumPhases] = '{256, 1, 0, 100, 250, 37};

  typedef struct packed {
    kind_e              kind;
    logic [CmdW-1:0]    cmd;
    logic [AddrW-1:0]   addr;
    logic [LenW-1:0]    off;
    logic [PieceW-1:0]  len;
    logic               near;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [LenW-1:0] len;
    logic [7:0]      st;
    int              nres;   // typed-in result count, or ByPredictor
  } row_t;

  typedef enum int {SinkOpen, SinkRandom, SinkPattern} sink_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [1:0] opcode, [9:2] chunk_length, [17:10] status_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [7:0] flash_opcode, [32:8] flash_address,
                                       // [40:33] data_offset, [49:41] data_length,
                                       // [50] near_full
  logic [KindW-1:0]    m_axis_tuser;   // kind
  logic                m_axis_tlast;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  flash_log_append_sequencer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer predictor: its own copy of pointers, phase and registers,
  // advanced once per accepted input beat.
  // ---------------------------------------------------------------------------
  phase_e              seq_phase  = PhIdle;
  logic [PtrW-1:0]     wr_ptr     = '0;
  logic [PtrW-1:0]     erased_ptr = '0;
  logic [LenW-1:0]     req_len    = '0;
  logic [LenW-1:0]     done_cnt   = '0;
  logic [PieceW-1:0]   piece_len  = '0;
  logic [MarginW-1:0]  margin_kb  = 10;
  logic                erase_en   = 1'b1;
  logic [PieceW-1:0]   chunk_cap  = 250;

  cmd_t fresh_cmds[$];   // commands caused by the beat just taken
  cmd_t due_cmds[$];     // commands still owed by the block, oldest first
  cmd_t typed_cmds[$];   // hand-written commands of the directed rows
  row_t dir_rows[$];

  int   cur_row   = ByPredictor;
  int   burst_left = 0;
  int   hold_ask  = 0;
  int   quiet     = 0;
  bit   failed    = 1'b0;
  cmd_t got, want;

  // near_full looks at the pointer as it stands when the command is issued
  function automatic void issue(kind_e k, logic [PtrW-1:0] a, logic [LenW-1:0] o,
                                logic [PieceW-1:0] l);
    cmd_t c;
    int   room;
    c.kind = k;
    case (k)
      KindWren:  c.cmd = CmdWren;
      KindErase: c.cmd = CmdErase;
      KindProg:  c.cmd = CmdProg;
      KindRdsr:  c.cmd = CmdRdsr;
      default:   c.cmd = CmdNone;
    endcase
    c.addr = a[AddrW-1:0];
    c.off  = o;
    c.len  = l;
    room   = (int'(wr_ptr) >= MemBytes) ? 0 : MemBytes - int'(wr_ptr);
    c.near = room < int'({margin_kb, 10'b0});
    c.last = 1'b0;
    fresh_cmds.push_back(c);
  endfunction

  // Piece = least of page space, bytes left and the chunk cap (zero cap acts as 1)
  function automatic void begin_piece();
    logic [PieceW-1:0] page_room, left, cap, p;
    logic [LenW-1:0]   rem;
    page_room = PieceW'(PageBytes) - {1'b0, wr_ptr[PageW-1:0]};
    rem       = req_len - done_cnt;
    left      = {1'b0, rem};
    cap       = (chunk_cap == '0) ? PieceW'(1) : chunk_cap;
    p = page_room;
    if (left < p) p = left;
    if (cap < p)  p = cap;
    piece_len = p;
    issue(KindWren, '0, '0, '0);
    issue(KindProg, wr_ptr, done_cnt, p);
    issue(KindRdsr, '0, '0, '0);
    seq_phase = PhProgWait;
  endfunction

  // Erase first when the erased area ahead (mod 2^26) does not cover the request
  function automatic void start_work();
    logic [PtrW-1:0] ahead;
    ahead = erased_ptr - wr_ptr;
    if (erase_en && ahead <= PtrW'(req_len)) begin
      issue(KindWren, '0, '0, '0);
      issue(KindErase, erased_ptr, '0, '0);
      issue(KindRdsr, '0, '0, '0);
      seq_phase = PhEraseWait;
    end else begin
      begin_piece();
    end
  endfunction

  function automatic void plan_commands(logic [1:0] op, logic [LenW-1:0] len,
                                        logic [7:0] st);
    cmd_t tail;
    fresh_cmds.delete();
    case (op)
      OpRestart: begin
        wr_ptr     = '0;
        erased_ptr = '0;
        req_len    = '0;
        done_cnt   = '0;
        piece_len  = '0;
        seq_phase  = PhIdle;
      end
      OpAppend: begin
        if (seq_phase == PhIdle) begin
          req_len  = len;
          done_cnt = '0;
          if (len == '0) issue(KindDone, '0, '0, '0);
          else           start_work();
        end
      end
      OpStatus: begin
        if (seq_phase == PhEraseWait) begin
          if (st != '0) begin
            issue(KindRdsr, '0, '0, '0);
          end else begin
            erased_ptr = erased_ptr + PtrW'(SectorBytes);
            start_work();
          end
        end else if (seq_phase == PhProgWait) begin
          if (st != '0) begin
            issue(KindRdsr, '0, '0, '0);
          end else begin
            done_cnt = done_cnt + piece_len[LenW-1:0];
            wr_ptr   = wr_ptr + PtrW'(piece_len);
            if (done_cnt >= req_len) begin
              seq_phase = PhIdle;
              issue(KindDone, '0, '0, '0);
            end else begin
              begin_piece();
            end
          end
        end
      end
      default: ;
    endcase
    if (fresh_cmds.size() != 0) begin
      tail      = fresh_cmds.pop_back();
      tail.last = 1'b1;
      fresh_cmds.push_back(tail);
    end
  endfunction

  function automatic void same_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sampled on the rising edge, inputs only move on the falling one.
  // Output beats are checked before the input beat of the same edge is
  // predicted, so a result can never meet its own expectation early.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_e'(m_axis_tuser);
        got.cmd  = m_axis_tdata[7:0];
        got.addr = m_axis_tdata[32:8];
        got.off  = m_axis_tdata[40:33];
        got.len  = m_axis_tdata[49:41];
        got.near = m_axis_tdata[50];
        got.last = m_axis_tlast;
        if (due_cmds.size() == 0) begin
          $error("command beat with nothing owed: kind %0d opcode 0x%0h",
                 m_axis_tuser, got.cmd);
          failed = 1'b1;
        end else begin
          want = due_cmds.pop_front();
          same_field("kind", 32'(want.kind), 32'(got.kind));
          same_field("flash_opcode", 32'(want.cmd), 32'(got.cmd));
          same_field("flash_address", 32'(want.addr), 32'(got.addr));
          same_field("data_offset", 32'(want.off), 32'(got.off));
          same_field("data_length", 32'(want.len), 32'(got.len));
          same_field("near_full", 32'(want.near), 32'(got.near));
          same_field("last", 32'(want.last), 32'(got.last));
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        plan_commands(s_axis_tdata[1:0], s_axis_tdata[9:2], s_axis_tdata[17:10]);
        // Hand-written rows replace the prediction; the predictor still tracks state
        if (cur_row >= 0 && dir_rows[cur_row].nres >= 0) begin
          repeat (dir_rows[cur_row].nres) due_cmds.push_back(typed_cmds.pop_front());
        end else begin
          foreach (fresh_cmds[i]) due_cmds.push_back(fresh_cmds[i]);
        end
      end

      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Downstream: ready follows a pattern of its own, switching mode now and then.
  // A hold request from the stimulus side forces a long stall, counted here.
  // ---------------------------------------------------------------------------
  initial begin : sink
    sink_mode_e mode;
    int         left;
    int         seen;
    int         tick;
    mode = SinkOpen;
    left = 0;
    seen = 0;
    tick = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_ask != seen) begin
        seen = hold_ask;
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 2));
          left = $urandom_range(8, 40);
        end
        left--;
        case (mode)
          SinkOpen:   m_axis_tready = 1'b1;
          SinkRandom: m_axis_tready = ($urandom_range(0, 99) < 55);
          default:    m_axis_tready = (tick % 5) < 3;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Upstream driving. Every task is entered and left on a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one beat and hold it until taken; bursts with random gaps between them
  task automatic drive_beat(logic [1:0] op, logic [LenW-1:0] len, logic [7:0] st, int row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'b0, st, len, op};
    cur_row       = row;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Register writes, one per cycle, only with the block quiet
  task automatic configure(logic [MarginW-1:0] m, logic e, logic [PieceW-1:0] c);
    cfg_we_i    = 1'b1;
    cfg_index_i = CfgStopMargin;
    cfg_data_i  = CfgDataW'(m);
    @(negedge clk_i);
    cfg_index_i = CfgEraseOnDemand;
    cfg_data_i  = CfgDataW'(e);
    @(negedge clk_i);
    cfg_index_i = CfgMaxChunk;
    cfg_data_i  = CfgDataW'(c);
    @(negedge clk_i);
    cfg_we_i  = 1'b0;
    margin_kb = m;
    erase_en  = e;
    chunk_cap = c;
  endtask

  // Finish any sequence with clean status replies, then let every command out
  task automatic wind_down();
    while (seq_phase != PhIdle) drive_beat(OpStatus, LenW'($urandom), '0, ByPredictor);
    s_axis_tvalid = 1'b0;
    while (due_cmds.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Mostly well-formed traffic for the current phase, with some noise mixed in.
  // counted is cleared for beats the block just drops.
  task automatic random_beat(output bit counted);
    int              r;
    int              pick;
    logic [1:0]      op;
    logic [LenW-1:0] len;
    logic [7:0]      st;
    r       = $urandom_range(0, 99);
    len     = LenW'($urandom);
    st      = 8'($urandom);
    counted = 1'b1;
    if (seq_phase == PhIdle) begin
      if (r < 4) begin
        op = OpRestart;
      end else if (r < 7) begin
        op = OpSpare;
        counted = 1'b0;
      end else if (r < 11) begin
        op = OpStatus;          // nothing to wait for
        counted = 1'b0;
      end else begin
        op = OpAppend;
        // tiny caps mean one piece per byte, so keep such requests short
        if (chunk_cap <= 4) begin
          len = LenW'($urandom_range(0, 12));
        end else begin
          pick = $urandom_range(0, 7);
          if (pick == 0)     len = '0;
          else if (pick < 3) len = LenW'($urandom_range(200, 255));
          else               len = LenW'($urandom_range(1, 255));
        end
      end
    end else begin
      if (r < 2) begin
        op = OpRestart;         // abort mid-sequence
      end else if (r < 4) begin
        op = OpSpare;
        counted = 1'b0;
      end else if (r < 8) begin
        op = OpAppend;          // busy, dropped
        counted = 1'b0;
      end else begin
        op = OpStatus;
        st = (r < 34) ? 8'($urandom_range(1, 255)) : 8'h00;
      end
    end
    drive_beat(op, len, st, ByPredictor);
  endtask

  function automatic cmd_t mk(kind_e k, logic [CmdW-1:0] c, logic [AddrW-1:0] a,
                              logic [LenW-1:0] o, logic [PieceW-1:0] l, logic lst);
    cmd_t r;
    r.kind = k;
    r.cmd  = c;
    r.addr = a;
    r.off  = o;
    r.len  = l;
    r.near = 1'b0;
    r.last = lst;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [LenW-1:0] len, logic [7:0] st,
                                  int nres);
    row_t r;
    r.op   = op;
    r.len  = len;
    r.st   = st;
    r.nres = nres;
    dir_rows.push_back(r);
  endfunction

  initial begin : stimulus
    int p;
    int done_items;
    bit counted;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CfgStopMargin;
    cfg_data_i    = '0;

    // Directed table, run on the reset register values
    // empty append straight after reset: done at once
    add_row(OpAppend, 8'd0, 8'h00, 1);
    typed_cmds.push_back(mk(KindDone, CmdNone, '0, '0, '0, 1'b1));
    add_row(OpStatus, 8'd0, 8'hFF, 0);           // status reply while idle
    add_row(OpSpare, 8'hFF, 8'hFF, 0);           // unused opcode
    // full-length append on fresh pointers: erase the first sector
    add_row(OpAppend, 8'd255, 8'h00, 3);
    typed_cmds.push_back(mk(KindWren, CmdWren, '0, '0, '0, 1'b0));
    typed_cmds.push_back(mk(KindErase, CmdErase, '0, '0, '0, 1'b0));
    typed_cmds.push_back(mk(KindRdsr, CmdRdsr, '0, '0, '0, 1'b1));
    add_row(OpAppend, 8'd5, 8'h00, 0);           // append while busy
    add_row(OpStatus, 8'd0, 8'hFF, 1);           // flash still busy: poll again
    typed_cmds.push_back(mk(KindRdsr, CmdRdsr, '0, '0, '0, 1'b1));
    add_row(OpStatus, 8'd0, 8'h80, ByPredictor);
    add_row(OpStatus, 8'hFF, 8'h01, ByPredictor);
    // erase done, first piece capped by the default chunk of 250
    add_row(OpStatus, 8'd0, 8'h00, 3);
    typed_cmds.push_back(mk(KindWren, CmdWren, '0, '0, '0, 1'b0));
    typed_cmds.push_back(mk(KindProg, CmdProg, '0, '0, 9'd250, 1'b0));
    typed_cmds.push_back(mk(KindRdsr, CmdRdsr, '0, '0, '0, 1'b1));
    add_row(OpStatus, 8'd0, 8'h00, ByPredictor); // remainder, short of the page end
    add_row(OpStatus, 8'd0, 8'h7F, ByPredictor);
    add_row(OpStatus, 8'd0, 8'h00, ByPredictor); // append done
    add_row(OpAppend, 8'd1, 8'h00, ByPredictor); // one byte to fill the page
    add_row(OpStatus, 8'd0, 8'h00, ByPredictor);
    add_row(OpAppend, 8'd200, 8'h00, ByPredictor);
    add_row(OpRestart, 8'hAA, 8'h55, 0);         // abort while a program is pending
    add_row(OpAppend, 8'd255, 8'h00, ByPredictor);
    add_row(OpStatus, 8'd0, 8'h00, ByPredictor);
    add_row(OpStatus, 8'd0, 8'h55, ByPredictor);
    add_row(OpRestart, 8'd0, 8'h00, 0);          // abort while a program is pending
    add_row(OpAppend, 8'd128, 8'h00, ByPredictor);
    add_row(OpStatus, 8'd0, 8'h00, ByPredictor);
    add_row(OpStatus, 8'd0, 8'h00, ByPredictor);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) drive_beat(dir_rows[i].op, dir_rows[i].len, dir_rows[i].st, i);

    // Random part, one register setting at a time
    for (p = 0; p < NumPhases; p++) begin
      wind_down();
      configure(MarginPlan[p], ErasePlan[p], ChunkPlan[p]);
      // long downstream stall while beats keep coming: the block must back up
      if (p == 0 || p == 3) hold_ask++;
      done_items = 0;
      while (done_items < PhaseItems) begin
        random_beat(counted);
        if (counted) done_items++;
      end
    end

    wind_down();
    repeat (DrainCycles) @(negedge clk_i);
    if (due_cmds.size() != 0) begin
      $error("%0d expected command beats never arrived", due_cmds.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
